>>> design/wvhp_pkg.sv
// Shared types, constants and helper functions for the wave header parser.
// No dependencies; used by wvhp_out_skid and wave_header_parser.
`timescale 1ns / 1ps
`default_nettype none

package wvhp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_RIFF = 3'd1,
        ST_BAD_WAVE = 3'd2,
        ST_BAD_FMT  = 3'd3,
        ST_NO_DATA  = 3'd4
    } t_status;

    // Byte positions within the header
    localparam logic [5:0] POS_SIZE     = 6'd4;
    localparam logic [5:0] POS_WAVE     = 6'd8;
    localparam logic [5:0] POS_FMT      = 6'd12;
    localparam logic [5:0] POS_FMT_LEN  = 6'd16;
    localparam logic [5:0] POS_TAG      = 6'd20;
    localparam logic [5:0] POS_CHANNELS = 6'd22;
    localparam logic [5:0] POS_RATE     = 6'd24;
    localparam logic [5:0] POS_BYTERATE = 6'd28;
    localparam logic [5:0] POS_ALIGN    = 6'd32;
    localparam logic [5:0] POS_BITS     = 6'd34;
    localparam logic [5:0] POS_SEARCH   = 6'd36;
    localparam logic [5:0] POS_LENGTH   = 6'd37;
    localparam logic [5:0] POS_LAST     = 6'd40;

    // Chunk-name matcher phases
    localparam logic [2:0] PH_WANT_D = 3'd1;
    localparam logic [2:0] PH_WANT_A = 3'd2;
    localparam logic [2:0] PH_WANT_T = 3'd3;
    localparam logic [2:0] PH_WANT_A2 = 3'd4;

    localparam logic [7:0] CH_D = 8'h64;  // 'd'
    localparam logic [7:0] CH_A = 8'h61;  // 'a'
    localparam logic [7:0] CH_T = 8'h74;  // 't'

    localparam int unsigned NUM_TAGS = 40;
    localparam logic [5:0]  TAG_UNKNOWN = 6'd40;

    localparam logic [15:0] KNOWN_TAGS [NUM_TAGS] = '{
        16'h0001, 16'h0002, 16'h0005, 16'h0006, 16'h0007,
        16'h0010, 16'h0011, 16'h0012, 16'h0013, 16'h0014, 16'h0015, 16'h0016,
        16'h0017,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026,
        16'h0030, 16'h0031, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h0040,
        16'h0050, 16'h0200, 16'h0202, 16'h0203,
        16'h0300, 16'h1000, 16'h1001, 16'h1002, 16'h1003, 16'h1004
    };

    // One result request
    typedef struct packed {
        t_status     status;
        logic [31:0] file_size;
        logic [31:0] fmt_length;
        logic [15:0] format_tag;
        logic [5:0]  tag_index;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
    } t_result;

    // Expected character of a magic word, by low four position bits
    function automatic logic [7:0] magic_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h52;  // R
            4'd1:    c = 8'h49;  // I
            4'd2:    c = 8'h46;  // F
            4'd3:    c = 8'h46;  // F
            4'd8:    c = 8'h57;  // W
            4'd9:    c = 8'h41;  // A
            4'd10:   c = 8'h56;  // V
            4'd11:   c = 8'h45;  // E
            4'd12:   c = 8'h66;  // f
            4'd13:   c = 8'h6d;  // m
            4'd14:   c = 8'h74;  // t
            4'd15:   c = 8'h20;  // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Position of a format tag in the known list, TAG_UNKNOWN if absent
    function automatic logic [5:0] tag_lookup(input logic [15:0] tag);
        logic [5:0] idx;
        idx = TAG_UNKNOWN;
        for (int k = NUM_TAGS - 1; k >= 0; k--) begin
            if (KNOWN_TAGS[k] == tag) begin
                idx = 6'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> design/wvhp_out_skid.sv
// Two-entry output stage (main register plus skid register) for results.
// Depends on wvhp_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module wvhp_out_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire wvhp_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output wvhp_pkg::t_result     o_data,
    input  wire logic             i_stall
);

    logic              r_main_valid, r_skid_valid;
    wvhp_pkg::t_result r_main, r_skid;
    logic              w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // Control: skid fills only when a new request meets a held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || w_pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || w_pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/wave_header_parser.sv
// Top level of the RIFF/WAVE header parser: byte state machine and field capture.
// Depends on wvhp_pkg and wvhp_out_skid.
//
// Takes one file byte per cycle with no gaps needed; the header state update and
// the result build are one short stage. Each result, caused by a byte or the
// end-of-stream flag, is registered in the two-entry output stage (in its skid
// entry while the main entry is held), so input is held off only once both
// entries are full. A file ends in exactly one result: status ok after the fourth
// data-length byte, or an error code; the parser then expects a new file.
`timescale 1ns / 1ps
`default_nettype none

module wave_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_end_of_stream,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [31:0]      o_file_size,
    output logic [31:0]      o_fmt_length,
    output logic [15:0]      o_format_tag,
    output logic [5:0]       o_tag_index,
    output logic [15:0]      o_channel_count,
    output logic [31:0]      o_sample_rate,
    output logic [31:0]      o_byte_rate,
    output logic [15:0]      o_block_align,
    output logic [15:0]      o_sample_bits,
    output logic [31:0]      o_data_length
);

    logic [5:0]  r_pos, n_pos;
    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_size, n_size;
    logic [31:0] r_fmt_len, n_fmt_len;
    logic [15:0] r_tag, n_tag;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_byte_rate, n_byte_rate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_length, n_length;

    logic              w_accept, w_full, w_push;
    logic [5:0]        w_pos;
    wvhp_pkg::t_status w_code;
    wvhp_pkg::t_result w_result, w_out;
    logic [1:0]        w_len_lane;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    // Out-of-range position restarts the file
    assign w_pos      = (r_pos > wvhp_pkg::POS_LAST) ? 6'd0 : r_pos;
    assign w_len_lane = w_pos[1:0] - 2'd1;

    // Which magic word (if any) covers this position
    always_comb begin
        if (w_pos < wvhp_pkg::POS_SIZE) begin
            w_code = wvhp_pkg::ST_BAD_RIFF;
        end else if (w_pos >= wvhp_pkg::POS_WAVE && w_pos < wvhp_pkg::POS_FMT) begin
            w_code = wvhp_pkg::ST_BAD_WAVE;
        end else if (w_pos >= wvhp_pkg::POS_FMT && w_pos < wvhp_pkg::POS_FMT_LEN) begin
            w_code = wvhp_pkg::ST_BAD_FMT;
        end else begin
            w_code = wvhp_pkg::ST_OK;
        end
    end

    // Header state update and result build
    always_comb begin
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_size      = r_size;
        n_fmt_len   = r_fmt_len;
        n_tag       = r_tag;
        n_channels  = r_channels;
        n_rate      = r_rate;
        n_byte_rate = r_byte_rate;
        n_align     = r_align;
        n_bits      = r_bits;
        n_length    = r_length;
        w_push      = 1'b0;

        // error result: zero fields, unknown tag index
        w_result           = '0;
        w_result.status    = wvhp_pkg::ST_NO_DATA;
        w_result.tag_index = wvhp_pkg::TAG_UNKNOWN;

        if (w_accept) begin
            n_pos = w_pos + 6'd1;
            if (i_end_of_stream) begin
                w_push = 1'b1;
                if (w_code != wvhp_pkg::ST_OK) begin
                    w_result.status = w_code;
                end
            end else if (w_code != wvhp_pkg::ST_OK) begin
                if (i_byte_value != wvhp_pkg::magic_char(w_pos[3:0])) begin
                    w_push          = 1'b1;
                    w_result.status = w_code;
                end
            end else if (w_pos < wvhp_pkg::POS_WAVE) begin
                n_size[8*w_pos[1:0] +: 8] = i_byte_value;
            end else if (w_pos < wvhp_pkg::POS_TAG) begin
                n_fmt_len[8*w_pos[1:0] +: 8] = i_byte_value;
            end else if (w_pos < wvhp_pkg::POS_CHANNELS) begin
                n_tag[8*w_pos[0] +: 8] = i_byte_value;
            end else if (w_pos < wvhp_pkg::POS_RATE) begin
                n_channels[8*w_pos[0] +: 8] = i_byte_value;
            end else if (w_pos < wvhp_pkg::POS_BYTERATE) begin
                n_rate[8*w_pos[1:0] +: 8] = i_byte_value;
            end else if (w_pos < wvhp_pkg::POS_ALIGN) begin
                n_byte_rate[8*w_pos[1:0] +: 8] = i_byte_value;
            end else if (w_pos < wvhp_pkg::POS_BITS) begin
                n_align[8*w_pos[0] +: 8] = i_byte_value;
            end else if (w_pos < wvhp_pkg::POS_SEARCH) begin
                n_bits[8*w_pos[0] +: 8] = i_byte_value;
            end else if (w_pos == wvhp_pkg::POS_SEARCH) begin
                // "data" matcher; stays at the search position until matched
                n_pos = wvhp_pkg::POS_SEARCH;
                if (r_phase == wvhp_pkg::PH_WANT_A2 && i_byte_value == wvhp_pkg::CH_A) begin
                    n_phase = wvhp_pkg::PH_WANT_D;
                    n_pos   = wvhp_pkg::POS_LENGTH;
                end else if (i_byte_value == wvhp_pkg::CH_D) begin
                    n_phase = wvhp_pkg::PH_WANT_A;
                end else if (r_phase == wvhp_pkg::PH_WANT_A
                             && i_byte_value == wvhp_pkg::CH_A) begin
                    n_phase = wvhp_pkg::PH_WANT_T;
                end else if (r_phase == wvhp_pkg::PH_WANT_T
                             && i_byte_value == wvhp_pkg::CH_T) begin
                    n_phase = wvhp_pkg::PH_WANT_A2;
                end else begin
                    n_phase = wvhp_pkg::PH_WANT_D;
                end
            end else begin
                n_length[8*w_len_lane +: 8] = i_byte_value;
                if (w_pos == wvhp_pkg::POS_LAST) begin
                    w_push                 = 1'b1;
                    w_result.status        = wvhp_pkg::ST_OK;
                    w_result.file_size     = r_size;
                    w_result.fmt_length    = r_fmt_len;
                    w_result.format_tag    = r_tag;
                    w_result.tag_index     = wvhp_pkg::tag_lookup(r_tag);
                    w_result.channel_count = r_channels;
                    w_result.sample_rate   = r_rate;
                    w_result.byte_rate     = r_byte_rate;
                    w_result.block_align   = r_align;
                    w_result.sample_bits   = r_bits;
                    w_result.data_length   = n_length;
                end
            end

            // any result restarts the file
            if (w_push) begin
                n_pos   = 6'd0;
                n_phase = wvhp_pkg::PH_WANT_D;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 6'd0;
            r_phase <= wvhp_pkg::PH_WANT_D;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
        end
    end

    // Header field capture; every lane is rewritten before an ok result
    always_ff @(posedge i_clk) begin
        r_size      <= n_size;
        r_fmt_len   <= n_fmt_len;
        r_tag       <= n_tag;
        r_channels  <= n_channels;
        r_rate      <= n_rate;
        r_byte_rate <= n_byte_rate;
        r_align     <= n_align;
        r_bits      <= n_bits;
        r_length    <= n_length;
    end

    wvhp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_data  (w_out),
        .i_stall (i_stall)
    );

    assign o_status        = w_out.status;
    assign o_file_size     = w_out.file_size;
    assign o_fmt_length    = w_out.fmt_length;
    assign o_format_tag    = w_out.format_tag;
    assign o_tag_index     = w_out.tag_index;
    assign o_channel_count = w_out.channel_count;
    assign o_sample_rate   = w_out.sample_rate;
    assign o_byte_rate     = w_out.byte_rate;
    assign o_block_align   = w_out.block_align;
    assign o_sample_bits   = w_out.sample_bits;
    assign o_data_length   = w_out.data_length;

endmodule

`default_nettype wire
